// ----- hw/rtl/ffsa_pkg.sv -----
// shared constants and types for the first-fit segment allocator
package ffsa_pkg;

    localparam int MAX_SEGMENTS = 64;
    localparam int ADDR_WIDTH   = 16;
    localparam int IDX_W        = $clog2(MAX_SEGMENTS);
    localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);
    localparam int SIZE_W       = ADDR_WIDTH + 1;
    localparam int ENTRY_W      = ADDR_WIDTH + SIZE_W + 1;

    localparam logic [1:0] REQ_ALLOC = 2'd0;
    localparam logic [1:0] REQ_FREE  = 2'd1;
    localparam logic [1:0] REQ_CHECK = 2'd2;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_INVALID = 3'd1;
    localparam logic [2:0] ST_NOMEM   = 3'd2;
    localparam logic [2:0] ST_RANGE   = 3'd3;
    localparam logic [2:0] ST_FULL    = 3'd4;

    typedef struct packed {
        logic [ADDR_WIDTH-1:0] start;
        logic [SIZE_W-1:0]     size;
        logic                  is_free;
    } seg_t;

    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        seg_t             wr_data;
    } mem_req_t;

endpackage

// ----- hw/rtl/ffsa_seg_ram.sv -----
// segment table memory, one write and one registered read port
module ffsa_seg_ram
(
    input  logic              clk,
    input  ffsa_pkg::mem_req_t req,
    output ffsa_pkg::seg_t     rd_data
);
    import ffsa_pkg::*;

    seg_t mem [MAX_SEGMENTS];

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data <= mem[req.rd_addr];
        end
    end
endmodule

// ----- hw/rtl/ffsa_ctrl.sv -----
// request sequencer: scan, shift, merge and statistics passes over the table
module ffsa_ctrl
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [ffsa_pkg::SIZE_W-1:0]    cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [1:0]                     req_type,
    input  logic [ffsa_pkg::ADDR_WIDTH-1:0] address,
    input  logic [ffsa_pkg::SIZE_W-1:0]    length,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [2:0]                     status,
    output logic [ffsa_pkg::ADDR_WIDTH-1:0] alloc_address,
    output logic [ffsa_pkg::SIZE_W-1:0]    free_total,
    output logic [ffsa_pkg::SIZE_W-1:0]    largest_free,
    output ffsa_pkg::mem_req_t             mreq,
    input  ffsa_pkg::seg_t                 rd_data,
    output logic                           busy
);
    import ffsa_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SCAN   = 4'd1;
    localparam logic [3:0] S_SCANW  = 4'd2;
    localparam logic [3:0] S_INS    = 4'd3;
    localparam logic [3:0] S_INSW   = 4'd4;
    localparam logic [3:0] S_NEIGH  = 4'd5;
    localparam logic [3:0] S_NEIGHW = 4'd6;
    localparam logic [3:0] S_REM    = 4'd7;
    localparam logic [3:0] S_REMW   = 4'd8;
    localparam logic [3:0] S_STAT   = 4'd9;
    localparam logic [3:0] S_STATW  = 4'd10;
    localparam logic [3:0] S_OUT    = 4'd11;

    localparam logic [SIZE_W-1:0] POOL_MAX = SIZE_W'(1) << ADDR_WIDTH;

    logic [3:0]            state_reg, state_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [CNT_W-1:0]      idx_reg, idx_next;
    logic [IDX_W-1:0]      hit_reg, hit_next;
    logic [1:0]            type_reg, type_next;
    logic [ADDR_WIDTH-1:0] addr_reg, addr_next;
    logic [SIZE_W-1:0]     len_reg, len_next;
    logic [2:0]            st_reg, st_next;
    logic [ADDR_WIDTH-1:0] aout_reg, aout_next;
    logic [SIZE_W-1:0]     tot_reg, tot_next;
    logic [SIZE_W-1:0]     big_reg, big_next;
    seg_t                  hold_reg, hold_next;
    seg_t                  prev_reg, prev_next;
    logic                  prevok_reg, prevok_next;
    logic                  nfree_reg, nfree_next;
    logic [1:0]            nstep_reg, nstep_next;
    logic [SIZE_W-1:0]     nsize_reg, nsize_next;
    logic                  outv_reg, outv_next;

    logic [SIZE_W-1:0]     cfg_sat;
    logic [SIZE_W:0]       seg_end;
    logic                  in_xfer, last;

    assign cfg_ready = (state_reg == S_IDLE) && !outv_reg;
    // a pending configuration write takes the cycle, the request waits
    assign in_stall  = (state_reg != S_IDLE) || outv_reg || cfg_valid;
    assign in_xfer   = in_valid && !in_stall;
    assign busy      = state_reg != S_IDLE;
    assign out_valid = outv_reg;
    assign status        = st_reg;
    assign alloc_address = aout_reg;
    assign free_total    = tot_reg;
    assign largest_free  = big_reg;

    assign cfg_sat = (cfg_data > POOL_MAX) ? POOL_MAX : cfg_data;
    assign seg_end = {1'b0, rd_data.start} + {1'b0, rd_data.size};
    assign last    = (idx_reg + CNT_W'(1)) >= count_reg;

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        hit_next    = hit_reg;
        type_next   = type_reg;
        addr_next   = addr_reg;
        len_next    = len_reg;
        st_next     = st_reg;
        aout_next   = aout_reg;
        tot_next    = tot_reg;
        big_next    = big_reg;
        hold_next   = hold_reg;
        prev_next   = prev_reg;
        prevok_next = prevok_reg;
        nfree_next  = nfree_reg;
        nstep_next  = nstep_reg;
        nsize_next  = nsize_reg;
        outv_next   = outv_reg;
        mreq        = '0;

        if (outv_reg && !out_stall)
        begin
            outv_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (cfg_valid && cfg_ready && cfg_data != '0)
                begin
                    mreq.wr_en   = 1'b1;
                    mreq.wr_addr = '0;
                    mreq.wr_data = '{start: '0, size: cfg_sat, is_free: 1'b1};
                    count_next   = CNT_W'(1);
                end
                else if (in_xfer)
                begin
                    type_next  = req_type;
                    addr_next  = address;
                    len_next   = length;
                    aout_next  = '0;
                    st_next    = ST_INVALID;
                    idx_next   = '0;
                    prevok_next = 1'b0;
                    if ((req_type == REQ_ALLOC || req_type == REQ_CHECK) && length == '0
                        || req_type == 2'd3)
                    begin
                        state_next = S_STAT;
                    end
                    else
                    begin
                        if (req_type == REQ_ALLOC)
                        begin
                            st_next = ST_NOMEM;
                        end
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                mreq.rd_en   = 1'b1;
                mreq.rd_addr = idx_reg[IDX_W-1:0];
                state_next   = S_SCANW;
            end
            S_SCANW:
            begin
                // default: continue the scan
                state_next = last ? S_STAT : S_SCAN;
                idx_next   = idx_reg + CNT_W'(1);
                prev_next  = rd_data;
                prevok_next = 1'b1;
                case (type_reg)
                    REQ_ALLOC:
                    begin
                        if (rd_data.is_free && rd_data.size >= len_reg)
                        begin
                            idx_next = '0;
                            if (rd_data.size != len_reg && count_reg >= CNT_W'(MAX_SEGMENTS))
                            begin
                                st_next    = ST_FULL;
                                state_next = S_STAT;
                            end
                            else
                            begin
                                st_next   = ST_OK;
                                aout_next = rd_data.start;
                                mreq.wr_en   = 1'b1;
                                mreq.wr_addr = idx_reg[IDX_W-1:0];
                                mreq.wr_data = '{start: rd_data.start, size: len_reg,
                                                 is_free: 1'b0};
                                if (rd_data.size != len_reg)
                                begin
                                    // carry the remainder up the table
                                    hold_next = '{start: rd_data.start + len_reg[ADDR_WIDTH-1:0],
                                                  size: rd_data.size - len_reg, is_free: 1'b1};
                                    idx_next   = idx_reg + CNT_W'(1);
                                    count_next = count_reg + CNT_W'(1);
                                    state_next = S_INS;
                                end
                                else
                                begin
                                    state_next = S_STAT;
                                end
                            end
                        end
                    end
                    REQ_FREE:
                    begin
                        if (rd_data.start == addr_reg && !rd_data.is_free)
                        begin
                            st_next   = ST_OK;
                            hit_next  = idx_reg[IDX_W-1:0];
                            nsize_next = rd_data.size;
                            nfree_next = prevok_reg && prev_reg.is_free;
                            prev_next  = prev_reg;
                            nstep_next = 2'd0;
                            state_next = last ? S_NEIGH : S_SCAN;
                            if (last)
                            begin
                                state_next = S_NEIGHW;
                                nstep_next = 2'd1;
                            end
                            else
                            begin
                                state_next = S_NEIGH;
                            end
                        end
                    end
                    REQ_CHECK:
                    begin
                        if (addr_reg >= rd_data.start && {1'b0, addr_reg} < seg_end)
                        begin
                            st_next = ((seg_end - {1'b0, addr_reg}) < {1'b0, len_reg})
                                      ? ST_RANGE : ST_OK;
                            idx_next   = '0;
                            state_next = S_STAT;
                        end
                    end
                    default:
                    begin
                        state_next = S_STAT;
                    end
                endcase
                if (state_next == S_STAT)
                begin
                    idx_next = '0;
                end
            end
            S_INS:
            begin
                mreq.rd_en   = 1'b1;
                mreq.rd_addr = idx_reg[IDX_W-1:0];
                state_next   = S_INSW;
            end
            S_INSW:
            begin
                // entries at or past the old count are unused, data ignored
                mreq.wr_en   = 1'b1;
                mreq.wr_addr = idx_reg[IDX_W-1:0];
                mreq.wr_data = hold_reg;
                hold_next    = rd_data;
                idx_next     = idx_reg + CNT_W'(1);
                if (idx_next >= count_reg)
                begin
                    idx_next   = '0;
                    state_next = S_STAT;
                end
                else
                begin
                    state_next = S_INS;
                end
            end
            S_NEIGH:
            begin
                // read the successor of the freed entry
                mreq.rd_en   = 1'b1;
                mreq.rd_addr = hit_reg + IDX_W'(1);
                state_next   = S_NEIGHW;
                nstep_next   = 2'd0;
            end
            S_NEIGHW:
            begin
                // merge with successor, then predecessor; write merged segment
                logic [SIZE_W-1:0] sz;
                logic              succ;
                succ = (nstep_reg == 2'd0) && rd_data.is_free;
                sz   = nsize_reg + (succ ? rd_data.size : '0);
                mreq.wr_en = 1'b1;
                if (nfree_reg)
                begin
                    mreq.wr_addr = hit_reg - IDX_W'(1);
                    mreq.wr_data = '{start: prev_reg.start, size: prev_reg.size + sz,
                                     is_free: 1'b1};
                end
                else
                begin
                    mreq.wr_addr = hit_reg;
                    mreq.wr_data = '{start: addr_reg, size: sz, is_free: 1'b1};
                end
                // number of entries to drop and first entry to fill
                nstep_next = {1'b0, succ} + {1'b0, nfree_reg};
                idx_next   = CNT_W'(hit_reg) + (nfree_reg ? CNT_W'(0) : CNT_W'(1));
                if (({1'b0, succ} + {1'b0, nfree_reg}) == 2'd0)
                begin
                    idx_next   = '0;
                    state_next = S_STAT;
                end
                else
                begin
                    count_next = count_reg - CNT_W'({1'b0, succ} + {1'b0, nfree_reg});
                    state_next = S_REM;
                end
            end
            S_REM:
            begin
                if (idx_reg >= count_reg)
                begin
                    idx_next   = '0;
                    state_next = S_STAT;
                end
                else
                begin
                    mreq.rd_en   = 1'b1;
                    mreq.rd_addr = IDX_W'(idx_reg + CNT_W'(nstep_reg));
                    state_next   = S_REMW;
                end
            end
            S_REMW:
            begin
                mreq.wr_en   = 1'b1;
                mreq.wr_addr = idx_reg[IDX_W-1:0];
                mreq.wr_data = rd_data;
                idx_next     = idx_reg + CNT_W'(1);
                state_next   = S_REM;
            end
            S_STAT:
            begin
                if (idx_reg == '0)
                begin
                    tot_next = '0;
                    big_next = '0;
                end
                mreq.rd_en   = 1'b1;
                mreq.rd_addr = idx_reg[IDX_W-1:0];
                state_next   = S_STATW;
            end
            S_STATW:
            begin
                if (rd_data.is_free)
                begin
                    tot_next = tot_reg + rd_data.size;
                    if (rd_data.size > big_reg)
                    begin
                        big_next = rd_data.size;
                    end
                end
                idx_next   = idx_reg + CNT_W'(1);
                state_next = last ? S_OUT : S_STAT;
            end
            S_OUT:
            begin
                if (!outv_reg)
                begin
                    outv_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= CNT_W'(1);
            outv_reg  <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            outv_reg  <= outv_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_reg    <= hit_next;
        type_reg   <= type_next;
        addr_reg   <= addr_next;
        len_reg    <= len_next;
        st_reg     <= st_next;
        aout_reg   <= aout_next;
        tot_reg    <= tot_next;
        big_reg    <= big_next;
        hold_reg   <= hold_next;
        prev_reg   <= prev_next;
        prevok_reg <= prevok_next;
        nfree_reg  <= nfree_next;
        nstep_reg  <= nstep_next;
        nsize_reg  <= nsize_next;
    end
endmodule

// ----- hw/rtl/ffsa_init.sv -----
// writes the single free segment into the table after reset
module ffsa_init
(
    input  logic               clk,
    input  logic               rst_n,
    input  ffsa_pkg::mem_req_t ctrl_req,
    output ffsa_pkg::mem_req_t mreq,
    output logic               init_done
);
    import ffsa_pkg::*;

    logic done_reg;

    assign init_done = done_reg;

    always_comb
    begin
        mreq = ctrl_req;
        if (!done_reg)
        begin
            mreq.wr_en   = 1'b1;
            mreq.wr_addr = '0;
            mreq.wr_data = '{start: '0, size: SIZE_W'(1) << ADDR_WIDTH, is_free: 1'b1};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b1;
        end
    end
endmodule

// ----- hw/rtl/first_fit_segment_allocator.sv -----
// Segment allocator top level. Each request takes one accepted transfer and
// yields one result. A request scans the segment table held in a synchronous
// RAM with one access per cycle, each entry read and then evaluated; zero-length
// allocations and checks and unknown request types skip the scan. It then may
// shift entries upward for a split or downward for a merge, each moved entry
// read and then written, and then sums free space over all entries. Input is
// stalled while a request runs, a result waits or a configuration write is
// offered. The first cycle after reset writes the initial free segment; no
// input is taken in that cycle.
module first_fit_segment_allocator
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ffsa_pkg::SIZE_W-1:0]     cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [1:0]                      req_type,
    input  logic [ffsa_pkg::ADDR_WIDTH-1:0] address,
    input  logic [ffsa_pkg::SIZE_W-1:0]     length,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [2:0]                      status,
    output logic [ffsa_pkg::ADDR_WIDTH-1:0] alloc_address,
    output logic [ffsa_pkg::SIZE_W-1:0]     free_total,
    output logic [ffsa_pkg::SIZE_W-1:0]     largest_free
);
    import ffsa_pkg::*;

    mem_req_t ctrl_req, ram_req;
    seg_t     rd_data;
    logic     init_done, busy, c_ready, c_stall;

    assign cfg_ready = c_ready && init_done;
    assign in_stall  = c_stall || !init_done;

    ffsa_ctrl u_ctrl
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid && init_done),
        .cfg_ready     (c_ready),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid && init_done),
        .in_stall      (c_stall),
        .req_type      (req_type),
        .address       (address),
        .length        (length),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .alloc_address (alloc_address),
        .free_total    (free_total),
        .largest_free  (largest_free),
        .mreq          (ctrl_req),
        .rd_data       (rd_data),
        .busy          (busy)
    );

    ffsa_init u_init
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl_req  (ctrl_req),
        .mreq      (ram_req),
        .init_done (init_done)
    );

    ffsa_seg_ram u_ram
    (
        .clk     (clk),
        .req     (ram_req),
        .rd_data (rd_data)
    );

`ifndef ASSERT_OFF
    // no transfer is taken while a request is running
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> in_stall)
        else $error("input taken while busy");
    // configuration only while idle with no pending result
    a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_valid && cfg_ready) |-> (!busy && !out_valid))
        else $error("config write while busy");
    // a stalled result stays valid with its status unchanged
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(status)))
        else $error("stalled result changed");
`endif
endmodule

// ----- verif/tb_first_fit_segment_allocator.sv -----
// testbench for the first-fit segment allocator: self-checking with a table predictor
`timescale 1ns / 1ps

module tb_first_fit_segment_allocator;
    import ffsa_pkg::*;

    localparam int REQ_BAD      = 3;
    localparam int CYCLE_LIMIT  = 4000000;

    typedef struct {
        logic [2:0]            status;
        logic [ADDR_WIDTH-1:0] alloc_address;
        logic [SIZE_W-1:0]     free_total;
        logic [SIZE_W-1:0]     largest_free;
    } reply_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [SIZE_W-1:0]     cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    logic [1:0]            req_type;
    logic [ADDR_WIDTH-1:0] address;
    logic [SIZE_W-1:0]     length;
    logic                  out_valid;
    logic                  out_stall;
    logic [2:0]            status;
    logic [ADDR_WIDTH-1:0] alloc_address;
    logic [SIZE_W-1:0]     free_total;
    logic [SIZE_W-1:0]     largest_free;

    // predictor copy of the segment table
    int unsigned pool_bytes;
    int unsigned tbl_start [MAX_SEGMENTS];
    int unsigned tbl_size  [MAX_SEGMENTS];
    bit          tbl_free  [MAX_SEGMENTS];
    int unsigned tbl_count;

    reply_t pending_replies[$];
    int     mismatches;
    int     cycles;
    int     sender_idle_pct;
    int     stall_pct;

    first_fit_segment_allocator uut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .req_type(req_type), .address(address), .length(length),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .alloc_address(alloc_address),
        .free_total(free_total), .largest_free(largest_free)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic void table_clear();
        tbl_start[0] = 0;
        tbl_size[0]  = pool_bytes;
        tbl_free[0]  = 1'b1;
        tbl_count    = 1;
    endfunction

    function automatic void drop_entry(int unsigned k);
        for (int unsigned c = k; c + 1 < tbl_count; c++)
        begin
            tbl_start[c] = tbl_start[c+1];
            tbl_size[c]  = tbl_size[c+1];
            tbl_free[c]  = tbl_free[c+1];
        end
        tbl_count--;
    endfunction

    function automatic reply_t predict_reply(int unsigned kind, int unsigned addr,
                                             int unsigned len);
        reply_t r;
        bit     done;
        int unsigned rest;
        int unsigned seg_end;
        r = '{ST_INVALID, '0, '0, '0};
        done = 1'b0;
        if (kind == REQ_ALLOC)
        begin
            if (len == 0)
                r.status = ST_INVALID;
            else
            begin
                r.status = ST_NOMEM;
                for (int unsigned i = 0; i < tbl_count && !done; i++)
                    if (tbl_free[i] && tbl_size[i] >= len)
                    begin
                        done = 1'b1;
                        rest = tbl_size[i] - len;
                        if (rest != 0 && tbl_count >= MAX_SEGMENTS)
                            r.status = ST_FULL;
                        else
                        begin
                            if (rest != 0)
                            begin
                                for (int unsigned c = tbl_count; c > i + 1; c--)
                                begin
                                    tbl_start[c] = tbl_start[c-1];
                                    tbl_size[c]  = tbl_size[c-1];
                                    tbl_free[c]  = tbl_free[c-1];
                                end
                                tbl_start[i+1] = tbl_start[i] + len;
                                tbl_size[i+1]  = rest;
                                tbl_free[i+1]  = 1'b1;
                                tbl_count++;
                            end
                            tbl_size[i] = len;
                            tbl_free[i] = 1'b0;
                            r.status = ST_OK;
                            r.alloc_address = tbl_start[i];
                        end
                    end
            end
        end
        else if (kind == REQ_FREE)
        begin
            for (int unsigned i = 0; i < tbl_count && !done; i++)
                if (tbl_start[i] == addr && !tbl_free[i])
                begin
                    done = 1'b1;
                    tbl_free[i] = 1'b1;
                    if (i + 1 < tbl_count && tbl_free[i+1])
                    begin
                        tbl_size[i] += tbl_size[i+1];
                        drop_entry(i + 1);
                    end
                    if (i > 0 && tbl_free[i-1])
                    begin
                        tbl_size[i-1] += tbl_size[i];
                        drop_entry(i);
                    end
                    r.status = ST_OK;
                end
        end
        else if (kind == REQ_CHECK && len != 0)
        begin
            for (int unsigned i = 0; i < tbl_count && !done; i++)
            begin
                seg_end = tbl_start[i] + tbl_size[i];
                if (addr >= tbl_start[i] && addr < seg_end)
                begin
                    done = 1'b1;
                    r.status = (seg_end - addr < len) ? ST_RANGE : ST_OK;
                end
            end
        end
        for (int unsigned i = 0; i < tbl_count; i++)
            if (tbl_free[i])
            begin
                r.free_total += tbl_size[i];
                if (tbl_size[i] > r.largest_free)
                    r.largest_free = tbl_size[i];
            end
        return r;
    endfunction

    // pick a start of a used segment, for frees that hit; a random address if none is used
    function automatic int unsigned used_start();
        int unsigned picks[$];
        for (int unsigned i = 0; i < tbl_count; i++)
            if (!tbl_free[i])
                picks.push_back(tbl_start[i]);
        if (picks.size() == 0)
            return $urandom_range(0, 65535);
        return picks[$urandom_range(0, picks.size() - 1)];
    endfunction

    // valid stays up after the transfer so back-to-back sends drive it once per edge
    task automatic send_request(int unsigned kind, int unsigned addr, int unsigned len);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= kind[1:0];
        address  <= addr[ADDR_WIDTH-1:0];
        length   <= len[SIZE_W-1:0];
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_replies.push_back(predict_reply(kind, addr, len));
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (6 * MAX_SEGMENTS + 20)
            @(posedge clk);
    endtask

    task automatic write_pool_size(int unsigned value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= value[SIZE_W-1:0];
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (value[SIZE_W-1:0] != 0)
        begin
            pool_bytes = (value[SIZE_W-1:0] > 65536) ? 65536 : value[SIZE_W-1:0];
            table_clear();
        end
    endtask

    task automatic random_requests(int count, int unsigned max_len);
        int unsigned pick;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
                send_request(REQ_ALLOC, $urandom_range(0, 65535),
                             ($urandom_range(0, 19) == 0) ? $urandom_range(0, 131071)
                                                         : $urandom_range(1, max_len));
            else if (pick < 75)
                send_request(REQ_FREE, ($urandom_range(0, 4) == 0)
                             ? $urandom_range(0, 65535) : used_start(),
                             $urandom_range(0, 131071));
            else if (pick < 97)
                send_request(REQ_CHECK, $urandom_range(0, pool_bytes > 0 ? 65535 : 0),
                             ($urandom_range(0, 1) == 0) ? $urandom_range(0, 131071)
                                                         : $urandom_range(0, max_len));
            else
                send_request(REQ_BAD, $urandom_range(0, 65535), $urandom_range(0, 131071));
        end
    endtask

    task automatic test_directed();
        send_request(REQ_CHECK, 0, 65536);
        send_request(REQ_CHECK, 65535, 2);
        send_request(REQ_ALLOC, 0, 0);
        send_request(REQ_CHECK, 0, 0);
        send_request(REQ_ALLOC, 0, 131071);
        send_request(REQ_ALLOC, 65535, 100);
        send_request(REQ_ALLOC, 0, 200);
        send_request(REQ_ALLOC, 0, 300);
        send_request(REQ_FREE, 100, 0);
        send_request(REQ_FREE, 50, 0);
        send_request(REQ_FREE, 300, 0);
        send_request(REQ_CHECK, 100, 200);
        send_request(REQ_CHECK, 100, 201);
        send_request(REQ_FREE, 0, 0);
        send_request(REQ_BAD, 65535, 131071);
        send_request(REQ_ALLOC, 0, 65536);
        send_request(REQ_ALLOC, 0, 1);
        send_request(REQ_FREE, 0, 0);
    endtask

    // fill the table with one-byte blocks until a split is refused
    task automatic test_table_full();
        write_pool_size(100);
        for (int n = 0; n < MAX_SEGMENTS + 1; n++)
            send_request(REQ_ALLOC, 0, 1);
        send_request(REQ_ALLOC, 0, 100 - MAX_SEGMENTS + 1);
        send_request(REQ_FREE, 5, 0);
        send_request(REQ_ALLOC, 0, 1);
    endtask

    task automatic test_pool_sizes();
        write_pool_size(0);
        send_request(REQ_CHECK, 50, 1);
        write_pool_size(1);
        random_requests(30, 2);
        write_pool_size(131071);
        send_request(REQ_ALLOC, 0, 65536);
        write_pool_size(65536);
    endtask

    task automatic test_random_phases();
        int idle_set[4] = '{0, 71, 0, 18};
        int stall_set[4] = '{0, 0, 71, 18};
        for (int p = 0; p < 4; p++)
        begin
            sender_idle_pct = idle_set[p];
            stall_pct = stall_set[p];
            write_pool_size((p == 1) ? 500 : $urandom_range(64, 65536));
            random_requests(180, 300);
            wait_drained();
            random_requests(100, 4000);
        end
        sender_idle_pct = 0;
        stall_pct = 0;
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    always @(posedge clk)
    begin
        reply_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_replies.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transfer status=%0d", status);
            end
            else
            begin
                want = pending_replies.pop_front();
                if (status !== want.status || alloc_address !== want.alloc_address ||
                    free_total !== want.free_total || largest_free !== want.largest_free)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("mismatch: exp st=%0d addr=%0d free=%0d big=%0d",
                                 want.status, want.alloc_address, want.free_total,
                                 want.largest_free);
                        $display("          got st=%0d addr=%0d free=%0d big=%0d",
                                 status, alloc_address, free_total, largest_free);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        mismatches = 0;
        cycles = 0;
        sender_idle_pct = 0;
        stall_pct = 0;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        in_valid = 1'b0;
        req_type = '0;
        address = '0;
        length = '0;
        out_stall = 1'b0;
        pool_bytes = 65536;
        table_clear();
        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_table_full();
        test_pool_sizes();
        test_random_phases();
        wait_drained();
        if (mismatches == 0 && pending_replies.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/ffsa_pkg.sv
hw/rtl/ffsa_seg_ram.sv
hw/rtl/ffsa_ctrl.sv
hw/rtl/ffsa_init.sv
hw/rtl/first_fit_segment_allocator.sv
verif/tb_first_fit_segment_allocator.sv
